// ===== sv/ntcf_pkg.sv =====
`timescale 1ns / 1ps
// ntcf_pkg: widths, fixed-point constants, register codes and the log2 normalizer
// for the ntc sample filter. No dependencies.
package ntcf_pkg;

  // configuration register widths and reset values
  localparam int BETA_W = 14;
  localparam int FS_W = 13;
  localparam int THR_W = 14;
  localparam int LIMIT_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [BETA_W-1:0] BETA_RST = 14'd3950;
  localparam logic [FS_W-1:0] FS_RST = 13'd3300;
  localparam logic [THR_W-1:0] THR_RST = 14'd100;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd3;

  // result field widths
  localparam int TEMP_W = 16;
  localparam int AVG_W = 12;
  localparam int T_W = 17;

  // log2 datapath: input, mantissa in Q30, log in Q16
  localparam int CONV_W = 16;
  localparam int K_W = 4;
  localparam int M_W = 31;
  localparam int LOG_W = 20;
  localparam int LOG_STEPS = 16;
  localparam int MUL_W = 31;

  // shared divider
  localparam int NUM_W = 50;
  localparam int DEN_W = 46;
  localparam int REM_W = 47;
  localparam int CNT_W = 6;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [63:0] INV_T0_WIDE = ((64'd1 << 40) * 64'd100 + 64'd14907) / 64'd29815;
  localparam logic [NUM_W-1:0] INV_T0_Q40 = INV_T0_WIDE[NUM_W-1:0];
  localparam logic [NUM_W-1:0] CENTI_NUM = NUM_W'(100) << 40;

  localparam logic signed [T_W-1:0] TEMP_MAX = 17'sd32767;
  localparam logic signed [T_W-1:0] TEMP_MIN = -17'sd27315;
  localparam logic [T_W-1:0] KELVIN_OFFSET = 17'd27315;
  localparam logic [NUM_W-1:0] K_MAX = NUM_W'(60082);

  // configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA,
    CFG_FULL_SCALE,
    CFG_THRESHOLD,
    CFG_RESAMPLE_LIMIT
  } cfg_reg_t;

  typedef struct packed {
    logic [K_W-1:0] k;
    logic [M_W-1:0] m;
  } norm_t;

  // integer part of log2 and the mantissa scaled into [2^30, 2^31)
  function automatic norm_t log_norm(input logic [CONV_W-1:0] n);
    norm_t r;
    logic [CONV_W+30-1:0] wide;
    r.k = '0;
    for (int i = 0; i < CONV_W; i++) begin
      if (n[i]) r.k = K_W'(i);
    end
    wide = {n, 30'b0} >> r.k;
    r.m = wide[M_W-1:0];
    return r;
  endfunction

endpackage

// ===== sv/ntcf_in_if.sv =====
`timescale 1ns / 1ps
// ntcf_in_if: sample channel (valid, ready, adc reading).
// Depends on nothing.
interface ntcf_in_if #(parameter int SAMPLE_BITS = 12);
  logic valid;
  logic ready;
  logic [SAMPLE_BITS-1:0] adc_code;
  modport source(output valid, adc_code, input ready);
  modport sink(input valid, adc_code, output ready);
endinterface

// ===== sv/ntcf_out_if.sv =====
`timescale 1ns / 1ps
// ntcf_out_if: result channel (valid, ready, temperature, group mean, clamp flag).
// Depends on nothing.
interface ntcf_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] temperature_centi;
  logic [11:0] group_average;
  logic clamped;
  modport source(output valid, temperature_centi, group_average, clamped, input ready);
  modport sink(input valid, temperature_centi, group_average, clamped, output ready);
endinterface

// ===== sv/ntcf_cfg_if.sv =====
`timescale 1ns / 1ps
// ntcf_cfg_if: register write channel (valid, ready, index, data).
// Depends on nothing.
interface ntcf_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [13:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/ntc_sample_filter_to_degc.sv =====
`timescale 1ns / 1ps
// ntc_sample_filter_to_degc: sample screening, group mean, rolling mean and
// beta-equation conversion on one shared multiplier and one shared divider.
// Depends on ntcf_pkg and the ntcf_in_if, ntcf_out_if, ntcf_cfg_if interfaces.
//
//  channel   dir   payload                                          beat when
//  in_ch     in    adc_code                                         valid & ready
//  out_ch    out   temperature_centi, group_average, clamped        valid & ready
//  cfg_ch    in    index, data (register write)                     valid & ready
//
// Each sample runs one conversion: 2 x 16 log2 squaring steps, one multiply,
// and up to two 50-step restoring divisions (a zero or over-range reading
// skips all of these); a sample that finishes a group adds a mean division,
// a rolling update and a second conversion.
// in_ch.ready is high only while idle; a result waits in the output register
// and the next sample is taken meanwhile. Synchronous active-low reset, no
// clearing pass; cfg writes are always taken.
module ntc_sample_filter_to_degc import ntcf_pkg::*; #(
  parameter int SAMPLES_PER_GROUP = 16,
  parameter int ROLLING_DEPTH = 8,
  parameter int SAMPLE_BITS = 12
) (
  input logic clk,
  input logic rst_n,
  ntcf_in_if.sink in_ch,
  ntcf_out_if.source out_ch,
  ntcf_cfg_if.sink cfg_ch
);

  localparam int GI_W = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;
  localparam int TOT_W = SAMPLE_BITS + $clog2(SAMPLES_PER_GROUP + 1);
  localparam int PTR_W = (ROLLING_DEPTH > 1) ? $clog2(ROLLING_DEPTH) : 1;
  localparam int FILL_W = $clog2(ROLLING_DEPTH + 1);
  localparam int SUM_W = SAMPLE_BITS + FILL_W;
  localparam logic [GI_W-1:0] GI_LAST = GI_W'(SAMPLES_PER_GROUP - 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ROLLING_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(ROLLING_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_CV_START, S_LOG_A, S_LOG_B, S_MUL, S_DIV, S_DIVEND,
    S_DONE, S_R_READ, S_R_UPD, S_R_MUL, S_R_SUM
  } state_t;

  typedef enum logic [1:0] {DK_LNB, DK_KELVIN, DK_MEAN, DK_ROLL} div_kind_t;

  state_t state_r;
  div_kind_t kind_r;
  logic pass_roll_r;

  // configuration
  logic [BETA_W-1:0] beta_r;
  logic [FS_W-1:0] full_scale_r;
  logic [THR_W-1:0] thr_r;
  logic [LIMIT_W-1:0] limit_r;

  // conversion datapath
  logic [SAMPLE_BITS-1:0] samp_r;
  logic [CONV_W-1:0] conv_s_r;
  logic [M_W-1:0] m_r;
  logic [LOG_W-1:0] y_r, ya_r;
  logic [LOG_W-1:0] mag_r;
  logic neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [REM_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic signed [T_W-1:0] t_r;
  logic flag_r;

  // screening and group state
  logic [GI_W-1:0] gidx_r;
  logic [LIMIT_W-1:0] retries_r;
  logic [TOT_W-1:0] total_r;
  logic signed [T_W-1:0] prev_r;

  // rolling store
  logic [SAMPLE_BITS-1:0] mem [ROLLING_DEPTH];
  logic [SAMPLE_BITS-1:0] old_r, mean_r;
  logic [PTR_W-1:0] wptr_r;
  logic [FILL_W-1:0] fill_r;
  logic [SUM_W-1:0] sumv_r, prod_r;

  // outputs
  logic out_valid_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic [AVG_W-1:0] out_avg_r;
  logic out_clamp_r;

  // combinational helpers
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [31:0] sq_hi;
  logic [M_W-1:0] m_sq;
  logic [LOG_W-1:0] y_sq;
  logic signed [LOG_W:0] d_log;
  logic [REM_W-1:0] rem_sh;
  logic rem_ge;
  logic [NUM_W-1:0] q_step;
  logic signed [NUM_W+1:0] inv_s;
  logic signed [T_W:0] tdiff;
  logic [T_W-1:0] tdiff_abs;
  logic [BETA_W-1:0] beta_eff;
  logic [CONV_W-1:0] fs_conv;
  logic [TOT_W-1:0] total_new;
  norm_t norm_s, norm_r;
  logic in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.temperature_centi = out_temp_r;
  assign out_ch.group_average = out_avg_r;
  assign out_ch.clamped = out_clamp_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority if (state_r == S_LOG_A || state_r == S_LOG_B) begin
      mul_a = m_r;
      mul_b = m_r;
    end else if (state_r == S_MUL) begin
      mul_a = MUL_W'(mag_r);
      mul_b = MUL_W'(LN2_Q30);
    end else if (state_r == S_R_MUL) begin
      mul_a = MUL_W'(FILL_FULL - fill_r);
      mul_b = MUL_W'(mean_r);
    end else begin
      mul_a = '0;
      mul_b = '0;
    end
    mul_p = mul_a * mul_b;
  end

  // one log2 squaring step
  always_comb begin
    sq_hi = mul_p[61:30];
    m_sq = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
    y_sq = y_r | (sq_hi[31] ? (LOG_W'(1) << (4'd15 - cnt_r[3:0])) : '0);
    d_log = $signed({1'b0, ya_r}) - $signed({1'b0, y_sq});
  end

  // one restoring divide step
  always_comb begin
    rem_sh = {rem_r[REM_W-2:0], q_r[NUM_W-1]};
    rem_ge = (rem_sh >= {1'b0, den_r});
    q_step = {q_r[NUM_W-2:0], rem_ge};
  end

  // reciprocal temperature, screening difference, misc
  always_comb begin
    inv_s = neg_r ? ($signed({2'b0, INV_T0_Q40}) - $signed({2'b0, q_r}))
                  : ($signed({2'b0, INV_T0_Q40}) + $signed({2'b0, q_r}));
    tdiff = $signed({t_r[T_W-1], t_r}) - $signed({prev_r[T_W-1], prev_r});
    tdiff_abs = tdiff[T_W] ? T_W'(-tdiff) : tdiff[T_W-1:0];
    beta_eff = (beta_r == '0) ? BETA_W'(1) : beta_r;
    fs_conv = CONV_W'(full_scale_r);
    total_new = total_r + TOT_W'(samp_r);
    norm_s = log_norm(conv_s_r);
    norm_r = log_norm(fs_conv - conv_s_r);
  end

  // rolling store, read registered
  always_ff @(posedge clk) begin
    if (state_r == S_R_UPD) mem[wptr_r] <= mean_r;
    old_r <= mem[wptr_r];
  end

  // sequencer and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r <= DK_LNB;
      pass_roll_r <= 1'b0;
      beta_r <= BETA_RST;
      full_scale_r <= FS_RST;
      thr_r <= THR_RST;
      limit_r <= LIMIT_RST;
      gidx_r <= '0;
      retries_r <= '0;
      total_r <= '0;
      prev_r <= '0;
      wptr_r <= '0;
      fill_r <= '0;
      sumv_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      // register writes
      if (cfg_ch.valid) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          CFG_BETA: beta_r <= cfg_ch.data[BETA_W-1:0];
          CFG_FULL_SCALE: full_scale_r <= cfg_ch.data[FS_W-1:0];
          CFG_THRESHOLD: thr_r <= cfg_ch.data[THR_W-1:0];
          CFG_RESAMPLE_LIMIT: limit_r <= cfg_ch.data[LIMIT_W-1:0];
        endcase
      end

      // result beat taken; a new result loaded in S_DONE keeps it set
      if (out_valid_r && out_ch.ready && !(state_r == S_DONE && pass_roll_r))
        out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            samp_r <= in_ch.adc_code;
            conv_s_r <= CONV_W'(in_ch.adc_code);
            pass_roll_r <= 1'b0;
            state_r <= S_CV_START;
          end
        end

        // clamp checks, then set up log2 of the reading
        S_CV_START: begin
          priority if (conv_s_r == '0) begin
            t_r <= TEMP_MAX;
            flag_r <= 1'b1;
            state_r <= S_DONE;
          end else if (conv_s_r >= fs_conv) begin
            t_r <= TEMP_MIN;
            flag_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            flag_r <= 1'b0;
            m_r <= norm_s.m;
            y_r <= LOG_W'(norm_s.k) << 16;
            cnt_r <= '0;
            state_r <= S_LOG_A;
          end
        end

        S_LOG_A: begin
          if (cnt_r == CNT_W'(LOG_STEPS - 1)) begin
            ya_r <= y_sq;
            m_r <= norm_r.m;
            y_r <= LOG_W'(norm_r.k) << 16;
            cnt_r <= '0;
            state_r <= S_LOG_B;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            m_r <= m_sq;
            y_r <= y_sq;
          end
        end

        S_LOG_B: begin
          cnt_r <= cnt_r + 1'b1;
          m_r <= m_sq;
          y_r <= y_sq;
          if (cnt_r == CNT_W'(LOG_STEPS - 1)) begin
            neg_r <= d_log[LOG_W];
            mag_r <= d_log[LOG_W] ? LOG_W'(-d_log) : d_log[LOG_W-1:0];
            state_r <= S_MUL;
          end
        end

        // |d| * ln2, then divide by 64 * beta
        S_MUL: begin
          q_r <= mul_p[NUM_W-1:0];
          rem_r <= '0;
          den_r <= DEN_W'(beta_eff) << 6;
          cnt_r <= '0;
          kind_r <= DK_LNB;
          state_r <= S_DIV;
        end

        S_DIV: begin
          q_r <= q_step;
          rem_r <= rem_ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NUM_W - 1)) state_r <= S_DIVEND;
        end

        S_DIVEND: begin
          unique case (kind_r)
            DK_LNB: begin
              if (inv_s[NUM_W+1] || inv_s == '0) begin
                t_r <= TEMP_MAX;
                state_r <= S_DONE;
              end else begin
                q_r <= CENTI_NUM + NUM_W'(inv_s[NUM_W:1]);
                den_r <= inv_s[DEN_W-1:0];
                rem_r <= '0;
                cnt_r <= '0;
                kind_r <= DK_KELVIN;
                state_r <= S_DIV;
              end
            end
            DK_KELVIN: begin
              if (q_r > K_MAX) t_r <= TEMP_MAX;
              else t_r <= $signed(q_r[T_W-1:0] - KELVIN_OFFSET);
              state_r <= S_DONE;
            end
            DK_MEAN: begin
              mean_r <= q_r[SAMPLE_BITS-1:0];
              state_r <= S_R_READ;
            end
            DK_ROLL: begin
              conv_s_r <= CONV_W'(q_r[SAMPLE_BITS-1:0]);
              pass_roll_r <= 1'b1;
              state_r <= S_CV_START;
            end
          endcase
        end

        S_DONE: begin
          if (pass_roll_r) begin
            // result beat waits for a free output register
            if (!out_valid_r || out_ch.ready) begin
              out_valid_r <= 1'b1;
              out_temp_r <= t_r[TEMP_W-1:0];
              out_avg_r <= AVG_W'(mean_r);
              out_clamp_r <= flag_r;
              state_r <= S_IDLE;
            end
          end else if (gidx_r != '0 && tdiff_abs >= T_W'(thr_r) && retries_r != '0) begin
            // drop the sample and retry
            retries_r <= retries_r - 1'b1;
            state_r <= S_IDLE;
          end else begin
            prev_r <= t_r;
            retries_r <= limit_r;
            if (gidx_r == GI_LAST) begin
              gidx_r <= '0;
              total_r <= '0;
              q_r <= NUM_W'(total_new);
              den_r <= DEN_W'(SAMPLES_PER_GROUP);
              rem_r <= '0;
              cnt_r <= '0;
              kind_r <= DK_MEAN;
              state_r <= S_DIV;
            end else begin
              gidx_r <= gidx_r + 1'b1;
              total_r <= total_new;
              state_r <= S_IDLE;
            end
          end
        end

        S_R_READ: state_r <= S_R_UPD;

        // replace the oldest entry, keep the running sum of filled entries
        S_R_UPD: begin
          if (fill_r == FILL_FULL) begin
            sumv_r <= sumv_r - SUM_W'(old_r) + SUM_W'(mean_r);
          end else begin
            sumv_r <= sumv_r + SUM_W'(mean_r);
            fill_r <= fill_r + 1'b1;
          end
          wptr_r <= (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
          state_r <= S_R_MUL;
        end

        // unfilled slots count as the new mean
        S_R_MUL: begin
          prod_r <= mul_p[SUM_W-1:0];
          state_r <= S_R_SUM;
        end

        S_R_SUM: begin
          q_r <= NUM_W'(sumv_r + prod_r);
          den_r <= DEN_W'(ROLLING_DEPTH);
          rem_r <= '0;
          cnt_r <= '0;
          kind_r <= DK_ROLL;
          state_r <= S_DIV;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL) else $error("rolling fill count overran the depth");

  a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gidx_r <= GI_LAST) else $error("group index overran the group size");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_CV_START) else $error("accepted beat did not start a conversion");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> den_r != '0) else $error("divider running with zero divisor");

endmodule

// ===== dv/ntc_sample_filter_to_degc_tb.sv =====
`timescale 1ns / 1ps
// ntc_sample_filter_to_degc_tb: self-checking bench for the ntc sample filter
// (screening, group mean, rolling mean, beta conversion). Depends on ntcf_pkg,
// the three channel interfaces and the ntc_sample_filter_to_degc top level.
module ntc_sample_filter_to_degc_tb import ntcf_pkg::*;;

  localparam int GROUP_LEN = 16;
  localparam int ROLL_LEN = 8;
  localparam int SETTLE_CYCLES = 400;
  localparam longint unsigned LN2_FIX = 64'd744261118;
  localparam longint unsigned INV_ROOM_Q40 = ((64'd1 << 40) * 64'd100 + 64'd14907) / 64'd29815;

  typedef struct {
    logic signed [15:0] temp;
    logic [11:0] avg;
    logic clamp;
  } reading_t;

  logic clk;
  logic rst_n;

  ntcf_in_if #(.SAMPLE_BITS(12)) in_ch();
  ntcf_out_if out_ch();
  ntcf_cfg_if cfg_ch();

  ntc_sample_filter_to_degc u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // register shadow
  int unsigned beta_reg;
  int unsigned fs_reg;
  int unsigned thr_reg;
  int unsigned limit_reg;

  // filter shadow state
  int unsigned slot_idx;
  int unsigned retries;
  int unsigned group_sum;
  int last_temp;
  int unsigned roll_mean[ROLL_LEN];
  bit roll_set[ROLL_LEN];

  reading_t pending_readings[$];
  int errors;
  int groups_done;
  int samples_sent;
  int readings_seen;
  int clamped_seen;
  int idle_pct;
  int stall_pct;

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // log2 in Q16 by integer part and truncating squaring
  function automatic longint log2_fixed(input int unsigned n);
    int unsigned k;
    longint unsigned m;
    longint y;
    k = 0;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    y = longint'(k) << 16;
    m = longint'(n) << (30 - (k & 15));
    for (int i = 1; i <= 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        y = y | (64'sd1 << (16 - i));
      end
    end
    return y;
  endfunction

  // beta equation in hundredths of a degree, with saturation and clamp flag
  function automatic int centi_from_reading(input int unsigned s, output bit clamp);
    longint d;
    longint inv;
    longint unsigned mag;
    longint unsigned term;
    longint unsigned b;
    longint unsigned kel;
    clamp = 1'b0;
    if (s == 0) begin
      clamp = 1'b1;
      return 32767;
    end
    if (s >= fs_reg) begin
      clamp = 1'b1;
      return -27315;
    end
    d = log2_fixed(s) - log2_fixed(fs_reg - s);
    mag = (d < 0) ? -d : d;
    b = (beta_reg == 0) ? 1 : beta_reg;
    term = (mag * LN2_FIX) / (b * 64);
    inv = longint'(INV_ROOM_Q40) + ((d < 0) ? -longint'(term) : longint'(term));
    if (inv <= 0) return 32767;
    kel = ((64'd100 << 40) + longint'(inv) / 2) / longint'(inv);
    if (kel > 60082) return 32767;
    return int'(kel) - 27315;
  endfunction

  // screening, group accumulation and rolling mean for one accepted sample
  function automatic void filter_sample(input logic [11:0] sample);
    int t;
    int diff;
    bit clamp;
    int unsigned mean;
    int unsigned sum;
    reading_t r;
    t = centi_from_reading(sample, clamp);
    if (slot_idx != 0) begin
      diff = (t < last_temp) ? last_temp - t : t - last_temp;
      if (diff >= int'(thr_reg) && retries != 0) begin
        retries--;
        return;
      end
    end
    last_temp = t;
    group_sum += sample;
    retries = limit_reg;
    slot_idx++;
    if (slot_idx < GROUP_LEN) return;
    mean = group_sum / GROUP_LEN;
    slot_idx = 0;
    group_sum = 0;
    for (int i = ROLL_LEN - 1; i > 0; i--) begin
      roll_mean[i] = roll_mean[i-1];
      roll_set[i] = roll_set[i-1];
    end
    roll_mean[0] = mean;
    roll_set[0] = 1'b1;
    sum = 0;
    for (int i = 0; i < ROLL_LEN; i++) sum += roll_set[i] ? roll_mean[i] : mean;
    t = centi_from_reading(sum / ROLL_LEN, clamp);
    r.temp = 16'(t);
    r.avg = 12'(mean);
    r.clamp = clamp;
    pending_readings.push_back(r);
    groups_done++;
  endfunction

  // send one sample beat, idling at random first
  task automatic send_sample(input logic [11:0] sample);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.adc_code <= sample;
    do @(posedge clk); while (!in_ch.ready);
    filter_sample(sample);
    samples_sent++;
  endtask

  // keep sending one value until a group completes
  task automatic fill_group(input logic [11:0] sample);
    int start;
    start = groups_done;
    while (groups_done == start) send_sample(sample);
  endtask

  // stop sending, wait for every reading, then let the block go idle
  task automatic drain_readings();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write beat
  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= 14'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_BETA: beta_reg = value & 14'h3fff;
      CFG_FULL_SCALE: fs_reg = value & 13'h1fff;
      CFG_THRESHOLD: thr_reg = value & 14'h3fff;
      CFG_RESAMPLE_LIMIT: limit_reg = value & 8'hff;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input int unsigned b, input int unsigned fs,
                           input int unsigned thr, input int unsigned lim);
    write_reg(CFG_BETA, b);
    write_reg(CFG_FULL_SCALE, fs);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_RESAMPLE_LIMIT, lim);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        $error("unexpected reading beat: temperature_centi %0d", out_ch.temperature_centi);
        errors++;
      end else begin
        reading_t e;
        e = pending_readings.pop_front();
        if (e.clamp) clamped_seen++;
        if (out_ch.temperature_centi !== e.temp) begin
          $error("temperature_centi: expected %0d, got %0d", e.temp, out_ch.temperature_centi);
          errors++;
        end
        if (out_ch.group_average !== e.avg) begin
          $error("group_average: expected %0d, got %0d", e.avg, out_ch.group_average);
          errors++;
        end
        if (out_ch.clamped !== e.clamp) begin
          $error("clamped: expected %0d, got %0d", e.clamp, out_ch.clamped);
          errors++;
        end
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // reset-value registers, zero reading, over-range readings
  task automatic test_defaults();
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd1);
    send_sample(12'd3299);
    send_sample(12'd3300);
    send_sample(12'd2048);
    fill_group(12'd1650);
    drain_readings();
  endtask

  // full-scale extremes: at 1 every nonzero reading clamps cold and zero clamps hot, deep range at 8191
  task automatic test_full_scale();
    write_all(3950, 1, 100, 3);
    send_sample(12'd0);
    fill_group(12'd1);
    fill_group(12'd4095);
    drain_readings();
    write_all(3950, 8191, 100, 3);
    fill_group(12'd4095);
    drain_readings();
  endtask

  // beta of zero, non-positive reciprocal and saturation above 327.67 degC
  task automatic test_saturation();
    write_all(0, 8191, 10000, 255);
    fill_group(12'd1);
    drain_readings();
    write_all(1000, 8191, 10000, 255);
    fill_group(12'd620);
    fill_group(12'd700);
    drain_readings();
    write_all(10000, 4095, 0, 0);
    fill_group(12'd100);
    drain_readings();
  endtask

  // screening with a zero threshold spends every retry on each slot
  task automatic test_screening();
    write_all(3950, 3300, 0, 3);
    send_sample(12'd1000);
    send_sample(12'd1000);
    send_sample(12'd2500);
    fill_group(12'd1600);
    drain_readings();
  endtask

  // mostly smooth readings around a drifting level, with jumps and extremes
  task automatic run_random(input int count, input int idle, input int stall);
    int base;
    int v;
    int r;
    idle_pct = idle;
    stall_pct = stall;
    base = $urandom_range(4095);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(31) == 0) base = $urandom_range(4095);
      r = $urandom_range(99);
      if (r < 80) v = base + $urandom_range(6) - 3;
      else if (r < 92) v = $urandom_range(4095);
      else if (r < 96) v = 0;
      else v = 4095;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      send_sample(12'(v));
      // one hold-off partway through to let the output side empty
      if (n == count / 2 && idle != 0) drain_readings();
    end
    drain_readings();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.adc_code <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_BETA;
    cfg_ch.data <= '0;
    idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    groups_done = 0;
    samples_sent = 0;
    readings_seen = 0;
    clamped_seen = 0;
    beta_reg = BETA_RST;
    fs_reg = FS_RST;
    thr_reg = THR_RST;
    limit_reg = LIMIT_RST;
    slot_idx = 0;
    retries = 0;
    group_sum = 0;
    last_temp = 0;
    for (int i = 0; i < ROLL_LEN; i++) begin
      roll_mean[i] = 0;
      roll_set[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_full_scale();
    test_saturation();
    test_screening();

    write_all(3950, 3300, 100, 3);
    run_random(260, 0, 0);
    write_all(10000, 4095, 0, 0);
    run_random(260, 51, 0);
    write_all(1000, 4095, 10000, 255);
    run_random(260, 0, 51);
    write_all($urandom_range(1000, 10000), $urandom_range(2048, 8191),
              $urandom_range(0, 10000), $urandom_range(0, 16));
    run_random(260, 8, 8);

    if (pending_readings.size() != 0) begin
      $error("%0d readings never arrived", pending_readings.size());
      errors++;
    end
    $display("covered %0d samples and %0d group readings (%0d clamped) over eleven settings",
             samples_sent, readings_seen, clamped_seen);
    $display("with idle and stall mixes of 0, 51 and 8 percent; %0d errors", errors);
    if (errors == 0) begin
      $display("ntc_sample_filter_to_degc: match");
    end else begin
      $display("ntc_sample_filter_to_degc: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(64'd200_000_000);
    $display("ntc_sample_filter_to_degc: mismatch");
    $finish;
  end

endmodule
